[design/bhs_pkg.sv]
// package: operation codes, controller states and control types for the history stack
`default_nettype none

package bhs_pkg;

    localparam int OP_W        = 2;
    localparam int OUT_ENTRY_W = 32;
    localparam int OCC_W       = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

endpackage

`default_nettype wire

[design/bhs_ctrl.sv]
// controller state machine: takes one command at a time and steps the datapath
`default_nettype none

module bhs_ctrl
    import bhs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    output t_ctrl      o_ctrl,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        o_busy      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_busy      = 1'b1;
                o_ctrl.exec = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/bhs_dp.sv]
// datapath: circular record store, newest pointer, record count and result registers
`default_nettype none

module bhs_dp
    import bhs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ctrl                  i_ctrl,
    input  wire logic [OP_W-1:0]        i_op,
    input  wire logic [OUT_ENTRY_W-1:0] i_entry_in,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [OUT_ENTRY_W-1:0]      o_entry_out,
    output logic [OCC_W-1:0]            o_occupancy,
    output logic                        o_is_empty,
    output logic                        o_is_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [ENTRY_WIDTH-1:0] mem [DEPTH];

    logic [OP_W-1:0]        r_op;
    logic [ENTRY_WIDTH-1:0] r_entry;
    logic [ENTRY_WIDTH-1:0] r_rd_data;
    logic [PTR_W-1:0]       r_ptr;
    logic [PTR_W-1:0]       n_ptr;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   r_valid;
    logic                   r_ok;
    logic                   n_ok;
    logic [OUT_ENTRY_W-1:0] r_out;
    logic [OUT_ENTRY_W-1:0] n_out;
    logic [OCC_W-1:0]       r_occ;
    logic                   r_empty;
    logic                   r_full;
    logic                   wr_en;
    logic [PTR_W-1:0]       slot_next;
    logic [63:0]            rd_wide;

    assign slot_next = (r_ptr == LAST_SLOT) ? '0 : r_ptr + PTR_W'(1);
    assign rd_wide   = 64'(r_rd_data);

    always_comb begin
        n_ptr = r_ptr;
        n_cnt = r_cnt;
        n_ok  = 1'b0;
        n_out = '0;
        wr_en = 1'b0;
        case (t_op'(r_op))
            OP_PUSH: begin
                wr_en = 1'b1;
                n_ptr = slot_next;
                n_ok  = 1'b1;
                // when full the slot after newest is the oldest, so it is overwritten
                if (r_cnt != FULL_CNT) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (r_cnt != '0) begin
                    n_ok  = 1'b1;
                    n_out = rd_wide[OUT_ENTRY_W-1:0];
                    if (t_op'(r_op) == OP_POP) begin
                        n_ptr = (r_ptr == '0) ? LAST_SLOT : r_ptr - PTR_W'(1);
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // store port: write on push, read of the newest slot when the command is taken
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && wr_en) begin
            mem[slot_next] <= r_entry;
        end
        if (i_ctrl.load) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op    <= i_op;
            r_entry <= ENTRY_WIDTH'(64'(i_entry_in));
        end
        if (i_ctrl.exec) begin
            r_ok    <= n_ok;
            r_out   <= n_out;
            r_occ   <= OCC_W'(n_cnt);
            r_empty <= (n_cnt == '0);
            r_full  <= (n_cnt == FULL_CNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.exec;
            if (i_ctrl.exec) begin
                r_ptr <= n_ptr;
                r_cnt <= n_cnt;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_ok        = r_ok;
    assign o_entry_out = r_out;
    assign o_occupancy = r_occ;
    assign o_is_empty  = r_empty;
    assign o_is_full   = r_full;

endmodule

`default_nettype wire

[design/bounded_history_stack_unit.sv]
// top level: bounded lifo history store that drops the oldest record on overflow
//
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// command   | start, busy           | i_op, i_entry_in
// result    | o_valid (one cycle)   | o_ok, o_entry_out, o_occupancy, o_is_empty,
//           |                       | o_is_full
//
// a command is taken when start is high and busy is low; busy is high for the
// one cycle that the datapath executes it, and no new command is taken then.
// the result strobe follows the transfer through the registered read of the
// record store and the registered result; a new command may be taken in the
// strobe cycle. the receiver cannot stall. synchronous reset empties the
// store at once; the store itself is not cleared.
`default_nettype none

module bounded_history_stack_unit
    import bhs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [OP_W-1:0]        i_op,
    input  wire logic [OUT_ENTRY_W-1:0] i_entry_in,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [OUT_ENTRY_W-1:0]      o_entry_out,
    output logic [OCC_W-1:0]            o_occupancy,
    output logic                        o_is_empty,
    output logic                        o_is_full
);

    t_ctrl ctrl;

    bhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    bhs_dp #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_op        (i_op),
        .i_entry_in  (i_entry_in),
        .o_valid     (o_valid),
        .o_ok        (o_ok),
        .o_entry_out (o_entry_out),
        .o_occupancy (o_occupancy),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full)
    );

`ifndef ASSERT_OFF
    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command transfer");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without an executed command");

    a_fail_zero_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_entry_out == '0)
        else $error("failed operation returned a nonzero record");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_empty && o_is_full))
        else $error("empty and full reported together");
`endif

endmodule

`default_nettype wire
